[design/bna_pkg.sv]
`default_nettype none
package bna_pkg;

	localparam int LIMB_W     = 32;
	localparam int DIGITS_DEF = 8;

	// Operation codes carried in the input tuser.
	localparam logic [2:0] K_ADD = 3'd0;
	localparam logic [2:0] K_SUB = 3'd1;
	localparam logic [2:0] K_MUL = 3'd2;
	localparam logic [2:0] K_QUO = 3'd3;
	localparam logic [2:0] K_REM = 3'd4;
	localparam logic [2:0] K_SHL = 3'd5;
	localparam logic [2:0] K_SHR = 3'd6;
	localparam logic [2:0] K_CMP = 3'd7;

	localparam logic [1:0] CMP_LT = 2'd0;
	localparam logic [1:0] CMP_EQ = 2'd1;
	localparam logic [1:0] CMP_GT = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DIV0  = 2'd1;
	localparam logic [1:0] ST_CLAMP = 2'd2;
	localparam logic [1:0] ST_CARRY = 2'd3;

	typedef enum logic [1:0] {
		U_ADD = 2'd0,
		U_SUB = 2'd1,
		U_MAC = 2'd2
	} unit_op_t;

	typedef struct packed {
		unit_op_t op;
		logic     mul_en;
	} unit_ctl_t;

endpackage
`default_nettype wire

[design/bna_limb_unit.sv]
`default_nettype none
module bna_limb_unit (
	input  wire                        clk,
	input  bna_pkg::unit_ctl_t         ctl,
	input  wire [bna_pkg::LIMB_W-1:0]  x,
	input  wire [bna_pkg::LIMB_W-1:0]  y,
	input  wire [bna_pkg::LIMB_W-1:0]  cin,
	output logic [bna_pkg::LIMB_W-1:0] lo,
	output logic [bna_pkg::LIMB_W-1:0] hi
);
	import bna_pkg::*;

	logic [2*LIMB_W-1:0] product_q;
	logic [2*LIMB_W-1:0] r;

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			product_q <= {{LIMB_W{1'b0}}, x} * {{LIMB_W{1'b0}}, y};
		end
	end

	// For a subtraction the upper half is all ones when a borrow occurs.
	always_comb begin
		case (ctl.op)
			U_ADD:   r = {{LIMB_W{1'b0}}, x} + {{LIMB_W{1'b0}}, y} + {{LIMB_W{1'b0}}, cin};
			U_SUB:   r = {{LIMB_W{1'b0}}, x} - {{LIMB_W{1'b0}}, y} - {{LIMB_W{1'b0}}, cin};
			U_MAC:   r = product_q + {{LIMB_W{1'b0}}, x} + {{LIMB_W{1'b0}}, cin};
			default: r = '0;
		endcase
	end

	assign lo = r[LIMB_W-1:0];
	assign hi = r[2*LIMB_W-1:LIMB_W];

endmodule
`default_nettype wire

[design/fixed_width_bignum_alu_unit.sv]
`default_nettype none
// Channel | Dir | Handshake        | Payload
// s       | in  | tvalid / tready  | tdata {shift_count, b_digit, a_digit}, tuser kind,
//         |     |                  | tlast final_limb
// m       | out | tvalid / tready  | tdata {status, compare_result, result_digit}, tlast last_digit
//
// Limb pairs are taken while s_tready is high. The final transfer starts the operation, during
// which s_tready is low: add, subtract and shifts make one pass over the limbs, multiply a
// multiply and an accumulate step per limb pair and a carry store per limb of a, quotient or
// remainder one pass per result bit, using the one shared limb adder and multiplier. DIGITS
// result transfers follow, each held until m_tready. Reset clears the sequencer and the load
// count; operand limbs at or above the load count read as zero.
module fixed_width_bignum_alu_unit #(
	parameter int DIGITS = bna_pkg::DIGITS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [71:0] s_tdata,  // a_digit[31:0], b_digit[63:32], shift_count[71:64]
	input  wire [2:0]  s_tuser,  // kind[2:0]
	input  wire        s_tlast,
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [39:0] m_tdata, // result_digit[31:0], compare_result[33:32], status[35:34]
	output logic       m_tlast
);
	import bna_pkg::*;

	localparam int DW   = $clog2(DIGITS);
	localparam int FW   = $clog2(DIGITS + 1);
	localparam int KW   = $clog2(32 * DIGITS);
	localparam int BITS = 32 * DIGITS;

	typedef enum logic [7:0] {
		S_LOAD   = 8'b0000_0001,
		S_ADDSUB = 8'b0000_0010,
		S_MUL_M  = 8'b0000_0100,
		S_MUL_A  = 8'b0000_1000,
		S_MUL_T  = 8'b0001_0000,
		S_DIV    = 8'b0010_0000,
		S_SHIFT  = 8'b0100_0000,
		S_OUT    = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [LIMB_W-1:0] a_q [DIGITS];
	logic [LIMB_W-1:0] b_q [DIGITS];
	logic [LIMB_W-1:0] w_q [DIGITS];
	logic [LIMB_W-1:0] x_q [DIGITS];
	logic [LIMB_W-1:0] t_q [DIGITS];
	logic [FW-1:0]     fill_q;
	logic [DW-1:0]     i_q, j_q;
	logic [KW-1:0]     k_q;
	logic [2:0]        kind_q;
	logic [7:0]        count_q;
	logic [1:0]        cmp_q, status_q;
	logic              bnz_q, sel_q, prev_q, lost_q;
	logic [LIMB_W-1:0] carry_q;

	logic [LIMB_W-1:0] in_a, in_b;
	logic [1:0]        cmp_n;
	logic              bnz_n, s_fire, m_fire, i_last, j_last;
	logic signed [8:0] fill_s, idx_i, src0, src1;
	logic [LIMB_W-1:0] a_i, a0, a1, b_val, shift_val, lost_mask, p_val, rem_i, div_s;
	logic [DW:0]       p_idx, p_hi;
	logic [2:0]        whole;
	logic [4:0]        bsh;
	logic [5:0]        bsh_c;
	logic signed [13:0] lost_lo;
	logic              lost_now, div_q;
	unit_ctl_t         u_ctl;
	logic [LIMB_W-1:0] u_x, u_y, u_cin, u_lo, u_hi;
	logic [LIMB_W-1:0] res;

	assign in_a   = s_tdata[31:0];
	assign in_b   = s_tdata[63:32];
	assign s_tready = (state_q == S_LOAD);
	assign s_fire = s_tvalid && s_tready;
	assign m_tvalid = (state_q == S_OUT);
	assign m_fire = m_tvalid && m_tready;
	assign i_last = (i_q == DW'(DIGITS - 1));
	assign j_last = (j_q == DW'(DIGITS - 1));

	// Later limbs are more significant, so a difference there decides the compare.
	always_comb begin
		cmp_n = cmp_q;
		bnz_n = bnz_q;
		if (fill_q < FW'(DIGITS)) begin
			if (in_a > in_b) begin
				cmp_n = CMP_GT;
			end else if (in_a < in_b) begin
				cmp_n = CMP_LT;
			end
			bnz_n = bnz_q | (in_b != '0);
		end
	end

	// Operand reads; limbs at or above the load count are zero.
	assign fill_s = $signed(9'(fill_q));
	assign idx_i  = $signed(9'(i_q));
	assign whole  = count_q[7:5];
	assign bsh    = count_q[4:0];
	assign bsh_c  = 6'd32 - {1'b0, bsh};

	always_comb begin
		if (state_q == S_DIV) begin
			src0 = $signed(9'(k_q[KW-1:5]));
		end else if (kind_q == K_SHL) begin
			src0 = idx_i - $signed({6'd0, whole});
		end else begin
			src0 = idx_i + $signed({6'd0, whole});
		end
		src1 = (kind_q == K_SHL) ? src0 - 9'sd1 : src0 + 9'sd1;
	end

	assign a_i = (idx_i < fill_s) ? a_q[i_q] : '0;
	assign a0  = (src0 >= 0 && src0 < fill_s) ? a_q[src0[DW-1:0]] : '0;
	assign a1  = (src1 >= 0 && src1 < fill_s) ? a_q[src1[DW-1:0]] : '0;

	always_comb begin
		if (state_q == S_MUL_M) begin
			b_val = ({1'b0, j_q} < fill_q) ? b_q[j_q] : '0;
		end else begin
			b_val = ({1'b0, i_q} < fill_q) ? b_q[i_q] : '0;
		end
	end

	always_comb begin
		if (kind_q == K_SHL) begin
			shift_val = (a0 << bsh) | ((bsh != '0) ? (a1 >> bsh_c) : '0);
		end else begin
			shift_val = (a0 >> bsh) | ((bsh != '0) ? (a1 << bsh_c) : '0);
		end
	end

	// Bits of limb i at or above 32*DIGITS - count leave the top on a shift up.
	assign lost_lo = $signed(14'(BITS)) - $signed(14'(count_q)) - $signed(14'({i_q, 5'd0}));
	always_comb begin
		if (lost_lo <= 14'sd0) begin
			lost_mask = '1;
		end else if (lost_lo >= 14'sd32) begin
			lost_mask = '0;
		end else begin
			lost_mask = '1 << lost_lo[4:0];
		end
	end
	assign lost_now = |(a_i & lost_mask);

	// Partial product index over the double-width product {x_q, w_q}.
	assign p_idx = {1'b0, i_q} + {1'b0, j_q};
	assign p_hi  = p_idx - (DW+1)'(DIGITS);
	always_comb begin
		if (i_q == '0) begin
			p_val = '0;
		end else if (p_idx < (DW+1)'(DIGITS)) begin
			p_val = w_q[p_idx[DW-1:0]];
		end else begin
			p_val = x_q[p_hi[DW-1:0]];
		end
	end

	// One restoring division step is a pass over the remainder limbs.
	always_comb begin
		if (k_q == KW'(BITS - 1)) begin
			rem_i = '0;
		end else begin
			rem_i = sel_q ? t_q[i_q] : x_q[i_q];
		end
		div_s = {rem_i[LIMB_W-2:0], (i_q == '0) ? a0[k_q[4:0]] : prev_q};
	end

	always_comb begin
		u_ctl.op     = U_ADD;
		u_ctl.mul_en = 1'b0;
		u_x   = a_i;
		u_y   = b_val;
		u_cin = {{(LIMB_W-1){1'b0}}, carry_q[0]};
		unique case (state_q)
			S_ADDSUB: begin
				u_ctl.op = (kind_q == K_SUB) ? U_SUB : U_ADD;
			end
			S_MUL_M: begin
				u_ctl.mul_en = 1'b1;
			end
			S_MUL_A: begin
				u_ctl.op = U_MAC;
				u_x   = p_val;
				u_cin = carry_q;
			end
			S_DIV: begin
				u_ctl.op = U_SUB;
				u_x   = div_s;
				u_cin = (i_q == '0) ? '0 : {{(LIMB_W-1){1'b0}}, carry_q[0]};
			end
			default: begin
			end
		endcase
	end

	bna_limb_unit u_unit (
		.clk (clk),
		.ctl (u_ctl),
		.x   (u_x),
		.y   (u_y),
		.cin (u_cin),
		.lo  (u_lo),
		.hi  (u_hi)
	);

	assign div_q = rem_i[LIMB_W-1] | ~u_hi[0];

	// Limb stores need no reset: reads are masked by the load count or follow a full write.
	always_ff @(posedge clk) begin
		if (s_fire && fill_q < FW'(DIGITS)) begin
			a_q[fill_q[DW-1:0]] <= in_a;
			b_q[fill_q[DW-1:0]] <= in_b;
		end
		unique case (state_q)
			S_ADDSUB: begin
				w_q[i_q] <= u_lo;
			end
			S_MUL_A: begin
				if (p_idx < (DW+1)'(DIGITS)) begin
					w_q[p_idx[DW-1:0]] <= u_lo;
				end else begin
					x_q[p_hi[DW-1:0]] <= u_lo;
				end
			end
			S_MUL_T: begin
				x_q[i_q] <= carry_q;
			end
			S_DIV: begin
				x_q[i_q] <= div_s;
				t_q[i_q] <= u_lo;
				if (i_last) begin
					w_q[k_q[KW-1:5]][k_q[4:0]] <= div_q;
				end
			end
			S_SHIFT: begin
				w_q[i_q] <= shift_val;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_LOAD;
			fill_q   <= '0;
			cmp_q    <= CMP_EQ;
			bnz_q    <= 1'b0;
			status_q <= ST_OK;
			kind_q   <= K_ADD;
			count_q  <= '0;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			sel_q    <= 1'b0;
			prev_q   <= 1'b0;
			lost_q   <= 1'b0;
			carry_q  <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (s_fire) begin
						if (fill_q < FW'(DIGITS)) begin
							fill_q <= fill_q + 1'b1;
						end
						cmp_q <= cmp_n;
						bnz_q <= bnz_n;
						if (s_tlast) begin
							kind_q   <= s_tuser;
							count_q  <= s_tdata[71:64];
							status_q <= ST_OK;
							i_q      <= '0;
							j_q      <= '0;
							k_q      <= KW'(BITS - 1);
							carry_q  <= '0;
							sel_q    <= 1'b0;
							lost_q   <= 1'b0;
							case (s_tuser)
								K_ADD: state_q <= S_ADDSUB;
								K_SUB: begin
									if (cmp_n == CMP_LT) begin
										status_q <= ST_CLAMP;
										state_q  <= S_OUT;
									end else begin
										state_q <= S_ADDSUB;
									end
								end
								K_MUL: state_q <= S_MUL_M;
								K_QUO, K_REM: begin
									if (!bnz_n) begin
										status_q <= ST_DIV0;
										state_q  <= S_OUT;
									end else begin
										state_q <= S_DIV;
									end
								end
								K_SHL, K_SHR: state_q <= S_SHIFT;
								default: state_q <= S_OUT;
							endcase
						end
					end
				end
				S_ADDSUB: begin
					carry_q <= u_hi;
					if (i_last) begin
						i_q     <= '0;
						state_q <= S_OUT;
						if (kind_q == K_ADD && u_hi[0]) begin
							status_q <= ST_CARRY;
						end
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_MUL_M: begin
					state_q <= S_MUL_A;
				end
				S_MUL_A: begin
					carry_q <= u_hi;
					// Any nonzero limb in the upper half can only grow, so the product overflows.
					if (p_idx >= (DW+1)'(DIGITS) && u_lo != '0) begin
						status_q <= ST_CARRY;
					end
					if (j_last) begin
						state_q <= S_MUL_T;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_MUL_M;
					end
				end
				S_MUL_T: begin
					if (carry_q != '0) begin
						status_q <= ST_CARRY;
					end
					carry_q <= '0;
					j_q     <= '0;
					if (i_last) begin
						i_q     <= '0;
						state_q <= S_OUT;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_MUL_M;
					end
				end
				S_DIV: begin
					carry_q <= u_hi;
					prev_q  <= rem_i[LIMB_W-1];
					if (i_last) begin
						i_q   <= '0;
						sel_q <= div_q;
						if (k_q == '0) begin
							state_q <= S_OUT;
						end else begin
							k_q <= k_q - 1'b1;
						end
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_SHIFT: begin
					lost_q <= lost_q | lost_now;
					if (i_last) begin
						i_q     <= '0;
						state_q <= S_OUT;
						if (kind_q == K_SHL && (lost_q || lost_now)) begin
							status_q <= ST_CARRY;
						end
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_OUT: begin
					if (m_fire) begin
						if (i_last) begin
							i_q     <= '0;
							fill_q  <= '0;
							cmp_q   <= CMP_EQ;
							bnz_q   <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end
				end
				default: state_q <= S_LOAD;
			endcase
		end
	end

	always_comb begin
		if (kind_q == K_CMP || status_q == ST_DIV0 || status_q == ST_CLAMP) begin
			res = '0;
		end else if (kind_q == K_REM) begin
			res = sel_q ? t_q[i_q] : x_q[i_q];
		end else begin
			res = w_q[i_q];
		end
	end

	assign m_tdata = {4'd0, status_q, cmp_q, res};
	assign m_tlast = i_last;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input taken while results pending");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(DIGITS))
		else $error("load count beyond limb count");

	a_back_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		m_fire && m_tlast |=> s_tready && fill_q == '0)
		else $error("no return to loading after last result");

	a_start_clean: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && s_tlast |=> !s_tready)
		else $error("final limb did not start an operation");

endmodule
`default_nettype wire
